// File: rtl/core/tfrgb_pkg.sv
// Shared types, format codes and arithmetic helpers for the texel-to-RGB blend unit.
// No dependencies; imported by every module of the block.
package tfrgb_pkg;

    // Texel format register codes.
    localparam logic [2:0] FMT_IA8      = 3'd0;
    localparam logic [2:0] FMT_IA16     = 3'd1;
    localparam logic [2:0] FMT_I8       = 3'd2;
    localparam logic [2:0] FMT_RGBA5551 = 3'd3;
    localparam logic [2:0] FMT_RGBA32   = 3'd4;

    // Fixed magenta backdrop.
    localparam logic [7:0] BACK_RED   = 8'd255;
    localparam logic [7:0] BACK_GREEN = 8'd0;
    localparam logic [7:0] BACK_BLUE  = 8'd255;

    // Decoded texel that travels from the decode stage to the blend stages.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       blend;
    } t_texel;

    // A 5-bit channel scaled to 8 bits as floor(c * 255 / 31).
    localparam logic [7:0] SCALE5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // Weighted sum c*a + back*(255-a); it never exceeds 255*255.
    function automatic logic [15:0] blend_sum(input logic [7:0] c, input logic [7:0] a,
                                              input logic [7:0] back);
        logic [7:0] inv_a;
        inv_a = 8'd255 - a;
        return (16'(c) * 16'(a)) + (16'(back) * 16'(inv_a));
    endfunction

    // Exact floor(x / 255) for x up to 255*255, by reciprocal with correction.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// File: rtl/core/texel_format_to_rgb_blend_unit.sv
// Top level of the texel-to-RGB blend unit: format register and the three-stage pipeline.
// Depends on tfrgb_pkg, tfrgb_decode and tfrgb_blend.
//
// Usage:
//   Input: drive i_texel_bits and raise i_start for one cycle per texel. A transaction
//   is accepted at each rising edge with i_start high and o_busy low. o_busy is always
//   low, so a texel can be accepted on every clock.
//   Output: each transaction yields one RGB result on o_red, o_green and o_blue, marked
//   by o_valid for exactly one cycle. The receiver cannot stall; it must take every
//   result in the cycle it appears.
//   Pipeline: each accepted texel passes through the decode, multiply and divide by
//   255 registers in that order. Throughput: one texel per clock, as every stage is
//   fully pipelined and the pipeline never stalls.
//   Configuration: i_cfg_we writes the low 3 bits of i_cfg_wdata into the format
//   register (0 IA8, 1 IA16, 2 I8, 3 RGBA5551, 4 RGBA32; other codes give the bare
//   magenta backdrop). Change it only when no transaction is in flight.
//   Reset: i_rst_n is synchronous, active low; it clears the pipeline valid bits and
//   sets the format to IA8. Texels in flight at reset are dropped.
module texel_format_to_rgb_blend_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_texel_bits,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);
    import tfrgb_pkg::*;

    logic [2:0] r_format;
    logic       accept;
    logic       dec_valid;
    t_texel     dec_texel;
    logic       sum_valid;

    // The pipeline never stalls, so it is never busy.
    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // Format register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_IA8;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_wdata;
        end
    end

    // Stage one: decode.
    tfrgb_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_format     (r_format),
        .i_texel_bits (i_texel_bits),
        .o_valid      (dec_valid),
        .o_texel      (dec_texel)
    );

    // Stages two and three: blend and divide.
    tfrgb_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dec_valid),
        .i_texel     (dec_texel),
        .o_sum_valid (sum_valid),
        .o_valid     (o_valid),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    // Every accepted transaction produces a result from the divide stage.
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_valid)
        else $error("accepted transaction produced no result");

    // No result appears without an earlier accepted transaction.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 3))
        else $error("result without an accepted transaction");

    // Decode valid moves into the multiply stage on the next edge.
    a_decode_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_valid |=> sum_valid)
        else $error("decoded texel lost before the multiply stage");

    // An unsupported format always yields the bare backdrop.
    a_backdrop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_format != FMT_IA8 && r_format != FMT_IA16 && r_format != FMT_I8
         && r_format != FMT_RGBA5551 && r_format != FMT_RGBA32 && !i_cfg_we)
        |-> ##3 (o_red == BACK_RED && o_green == BACK_GREEN && o_blue == BACK_BLUE))
        else $error("unsupported format did not give the backdrop");

endmodule

// File: rtl/core/tfrgb_decode.sv
// First pipeline stage: unpacks a raw texel into red, green, blue and alpha bytes.
// Depends on tfrgb_pkg for the format codes, the 5-bit scale table and t_texel.
module tfrgb_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2:0]            i_format,
    input  logic [31:0]           i_texel_bits,
    output logic                  o_valid,
    output tfrgb_pkg::t_texel     o_texel
);
    import tfrgb_pkg::*;

    logic   r_valid;
    t_texel r_texel;
    t_texel n_texel;

    // Decode the texel under the configured format.
    always_comb begin
        n_texel.red   = BACK_RED;
        n_texel.green = BACK_GREEN;
        n_texel.blue  = BACK_BLUE;
        n_texel.alpha = 8'd0;
        n_texel.blend = 1'b0;
        case (i_format)
            FMT_IA8: begin
                // Multiplying a nibble by 17 replicates it into both halves.
                n_texel.red   = {i_texel_bits[7:4], i_texel_bits[7:4]};
                n_texel.green = {i_texel_bits[7:4], i_texel_bits[7:4]};
                n_texel.blue  = {i_texel_bits[7:4], i_texel_bits[7:4]};
                n_texel.alpha = {i_texel_bits[3:0], i_texel_bits[3:0]};
                n_texel.blend = 1'b1;
            end
            FMT_IA16: begin
                n_texel.red   = i_texel_bits[15:8];
                n_texel.green = i_texel_bits[15:8];
                n_texel.blue  = i_texel_bits[15:8];
                n_texel.alpha = i_texel_bits[7:0];
                n_texel.blend = 1'b1;
            end
            FMT_I8: begin
                n_texel.red   = i_texel_bits[7:0];
                n_texel.green = i_texel_bits[7:0];
                n_texel.blue  = i_texel_bits[7:0];
            end
            FMT_RGBA5551: begin
                n_texel.red   = SCALE5[i_texel_bits[15:11]];
                n_texel.green = SCALE5[i_texel_bits[10:6]];
                n_texel.blue  = SCALE5[i_texel_bits[5:1]];
                n_texel.alpha = {8{i_texel_bits[0]}};
                n_texel.blend = 1'b1;
            end
            FMT_RGBA32: begin
                n_texel.red   = i_texel_bits[31:24];
                n_texel.green = i_texel_bits[23:16];
                n_texel.blue  = i_texel_bits[15:8];
                n_texel.alpha = i_texel_bits[7:0];
                n_texel.blend = 1'b1;
            end
            default: begin
                // Unsupported formats give the bare backdrop.
                n_texel.blend = 1'b0;
            end
        endcase
    end

    // Stage register; only the valid bit needs reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_texel <= n_texel;
    end

    assign o_valid = r_valid;
    assign o_texel = r_texel;

endmodule

// File: rtl/core/tfrgb_blend.sv
// Second and third pipeline stages: weighted sums onto the backdrop, then division by 255.
// Depends on tfrgb_pkg for t_texel, the backdrop constants, blend_sum and div255.
module tfrgb_blend (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  tfrgb_pkg::t_texel     i_texel,
    output logic                  o_sum_valid,
    output logic                  o_valid,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue
);
    import tfrgb_pkg::*;

    logic        r_sum_valid;
    logic        r_sum_blend;
    logic [15:0] r_sum_red;
    logic [15:0] r_sum_green;
    logic [15:0] r_sum_blue;
    logic [15:0] n_sum_red;
    logic [15:0] n_sum_green;
    logic [15:0] n_sum_blue;

    logic        r_valid;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;

    // Multiply stage: unblended channels pass through in the low byte.
    always_comb begin
        if (i_texel.blend) begin
            n_sum_red   = blend_sum(i_texel.red,   i_texel.alpha, BACK_RED);
            n_sum_green = blend_sum(i_texel.green, i_texel.alpha, BACK_GREEN);
            n_sum_blue  = blend_sum(i_texel.blue,  i_texel.alpha, BACK_BLUE);
        end else begin
            n_sum_red   = 16'(i_texel.red);
            n_sum_green = 16'(i_texel.green);
            n_sum_blue  = 16'(i_texel.blue);
        end
    end

    // Divide stage: truncating division by 255 for blended texels.
    always_comb begin
        if (r_sum_blend) begin
            n_red   = div255(r_sum_red);
            n_green = div255(r_sum_green);
            n_blue  = div255(r_sum_blue);
        end else begin
            n_red   = r_sum_red[7:0];
            n_green = r_sum_green[7:0];
            n_blue  = r_sum_blue[7:0];
        end
    end

    // Valid bits for both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_sum_valid <= i_valid;
            r_valid     <= r_sum_valid;
        end
    end

    // Payload registers for both stages.
    always_ff @(posedge i_clk) begin
        r_sum_blend <= i_texel.blend;
        r_sum_red   <= n_sum_red;
        r_sum_green <= n_sum_green;
        r_sum_blue  <= n_sum_blue;
        r_red       <= n_red;
        r_green     <= n_green;
        r_blue      <= n_blue;
    end

    assign o_sum_valid = r_sum_valid;
    assign o_valid     = r_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

endmodule
